// File: rtl/modbus_meter_poll_sequencer_macros.svh
// Assertion macros for the Modbus meter poll sequencer.
// Define ASSERT_OFF to compile the checks away; no other dependencies.
`ifndef MODBUS_METER_POLL_SEQUENCER_MACROS_SVH
`define MODBUS_METER_POLL_SEQUENCER_MACROS_SVH
`ifndef ASSERT_OFF
`define MMPS_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("%m: check failed");
`define MMPS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");
`define MMPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define MMPS_ASSERT_ALWAYS(label, clk, rst, cond)
`define MMPS_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define MMPS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/mmps_pkg.sv
// Shared types, codes and request frames of the Modbus meter poll sequencer.
// No dependencies.
package mmps_pkg;

  localparam int FRAME_DEPTH_DEF = 27;
  localparam int POLL_W          = 18;
  localparam int SEND_W          = 17;
  localparam int LEN_R1          = 27;
  localparam int LEN_SHORT       = 9;
  localparam int MS_PER_S        = 1000;
  localparam int REQ_LEN         = 8;

  localparam logic [7:0]  POLL_INTERVAL_RST = 8'd30;
  localparam logic [15:0] TIMEOUT_RST       = 16'd1000;

  // configuration register indexes
  localparam logic CFG_POLL_INTERVAL = 1'b0;
  localparam logic CFG_TIMEOUT       = 1'b1;

  // input item kinds
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_BYTE = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_TX    = 2'd0;
  localparam logic [1:0] KIND_QTY   = 2'd1;
  localparam logic [1:0] KIND_EVENT = 2'd2;

  // event codes
  localparam logic [1:0] EV_DONE    = 2'd0;
  localparam logic [1:0] EV_PARSE   = 2'd1;
  localparam logic [1:0] EV_TIMEOUT = 2'd2;

  // poll phases
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_WAIT_R1 = 2'd1;
  localparam logic [1:0] PH_WAIT_R2 = 2'd2;
  localparam logic [1:0] PH_WAIT_R3 = 2'd3;

  // quantity ids
  localparam logic [2:0] QID_ENERGY = 3'd0;
  localparam logic [2:0] QID_SUPPLY = 3'd1;
  localparam logic [2:0] QID_RETURN = 3'd2;
  localparam logic [2:0] QID_DELTA  = 3'd3;
  localparam logic [2:0] QID_VOLUME = 3'd4;
  localparam logic [2:0] QID_FLOW   = 3'd5;
  localparam logic [2:0] QID_POWER  = 3'd6;

  // request selects and frames
  localparam logic [1:0] REQ_R1 = 2'd0;
  localparam logic [1:0] REQ_R2 = 2'd1;
  localparam logic [1:0] REQ_R3 = 2'd2;
  localparam logic [63:0] R1_FRAME = 64'h0103_0000_000C_45CF;
  localparam logic [63:0] R2_FRAME = 64'h0103_000C_0002_0408;
  localparam logic [63:0] R3_FRAME = 64'h0103_000E_0002_A5C8;

  // response header
  localparam logic [7:0] MB_ADDR         = 8'h01;
  localparam logic [7:0] MB_FUNC         = 8'h03;
  localparam logic [7:0] HDR_R1_COUNT    = 8'h18;
  localparam logic [7:0] HDR_SHORT_COUNT = 8'h04;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
    logic       rx_last;
  } item_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [7:0]  tx_byte;
    logic        tx_end;
    logic [2:0]  quantity_id;
    logic [31:0] quantity_value;
    logic [1:0]  event_code;
    logic [1:0]  event_phase;
    logic        run_last;
  } result_t;

  function automatic logic [7:0] req_byte(input logic [1:0] sel, input logic [2:0] idx);
    logic [63:0] frame;
    case (sel)
      REQ_R1:  frame = R1_FRAME;
      REQ_R2:  frame = R2_FRAME;
      REQ_R3:  frame = R3_FRAME;
      default: frame = R1_FRAME;
    endcase
    return frame[8 * (3'd7 - idx) +: 8];
  endfunction

endpackage

// File: rtl/modbus_meter_poll_sequencer.sv
// Modbus RTU poll sequencer for a heat meter (read holding registers).
// Each item's results pass through the plan registers and then the output register.
// One result per cycle while result_stall is low; an item yields up to 13
// results, drained by the single output register from the result plan.
// Reset (rst, synchronous): idle phase, timers and frame count cleared,
// poll interval 30 s, timeout 1000 ms. Depends on mmps_pkg and the macros.
`include "modbus_meter_poll_sequencer_macros.svh"

module modbus_meter_poll_sequencer #(
  parameter int FRAME_DEPTH = mmps_pkg::FRAME_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // item channel
  input  logic              item_valid,
  output logic              item_stall,
  input  mmps_pkg::item_t   item,
  // result channel
  output logic              result_valid,
  input  logic              result_stall,
  output mmps_pkg::result_t result,
  // configuration writes
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [15:0]       cfg_data
);

  import mmps_pkg::*;

  localparam int CNT_W = $clog2(FRAME_DEPTH + 1);
  localparam int IDX_W = $clog2(FRAME_DEPTH);

  // configuration; the poll interval is kept in milliseconds
  logic [POLL_W-1:0] poll_limit_ms;
  logic [15:0]       timeout_lim;

  // poll state
  logic [1:0]        phase, phase_next;
  logic [POLL_W-1:0] since_poll_ms, since_poll_next;
  logic [SEND_W-1:0] since_send_ms, since_send_next;
  logic [CNT_W-1:0]  rx_count, rx_count_next;
  logic [7:0]        frame_store [FRAME_DEPTH];

  // result plan: leading event, quantities, request bytes, trailing event
  logic       plan_pre, plan_post;
  logic [1:0] plan_code, plan_ev_phase;
  logic [2:0] plan_qty, plan_qid;
  logic [3:0] plan_req;
  logic [1:0] plan_sel;

  logic       new_pre, new_post;
  logic [1:0] new_code, new_ev_phase;
  logic [2:0] new_qty, new_qid;
  logic [3:0] new_req;
  logic [1:0] new_sel;

  logic accept, load, pending, last_now, store_we;
  logic [POLL_W-1:0] poll_inc;
  logic [SEND_W-1:0] send_inc;
  logic [CNT_W-1:0]  cnt_inc;
  logic hdr_r1, hdr_short, timed_out, start, phase_a_idle;
  logic [1:0] phase_a;
  logic [31:0] qty_word;
  logic [2:0] req_idx;
  result_t result_next;

  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------------------
  // Handshake: a new item may transfer in the cycle in which the last result
  // of the previous plan moves into the output register.
  // ---------------------------------------------------------------------------
  assign pending    = plan_pre || (plan_qty != 3'd0) || (plan_req != 4'd0) || plan_post;
  assign load       = pending && (!result_valid || !result_stall);
  assign item_stall = pending && !(load && last_now);
  assign accept     = item_valid && !item_stall;

  // ---------------------------------------------------------------------------
  // Item processing: timers, frame collection, parse decision and new plan.
  // ---------------------------------------------------------------------------
  assign poll_inc = (since_poll_ms == '1) ? since_poll_ms : since_poll_ms + 1'b1;
  assign send_inc = (since_send_ms == '1) ? since_send_ms : since_send_ms + 1'b1;
  assign cnt_inc  = (rx_count < CNT_W'(FRAME_DEPTH)) ? rx_count + 1'b1 : rx_count;

  // a passing frame is at least nine bytes, so the header is already stored
  assign hdr_r1    = (frame_store[0] == MB_ADDR) && (frame_store[1] == MB_FUNC)
                  && (frame_store[2] == HDR_R1_COUNT);
  assign hdr_short = (frame_store[0] == MB_ADDR) && (frame_store[1] == MB_FUNC)
                  && (frame_store[2] == HDR_SHORT_COUNT);

  assign timed_out    = (phase != PH_IDLE) && (send_inc > {1'b0, timeout_lim});
  assign phase_a      = timed_out ? PH_IDLE : phase;
  assign phase_a_idle = (phase_a == PH_IDLE);
  assign start        = phase_a_idle && (poll_inc >= poll_limit_ms);

  always_comb begin
    phase_next      = phase;
    since_poll_next = since_poll_ms;
    since_send_next = since_send_ms;
    rx_count_next   = rx_count;
    store_we        = 1'b0;
    new_pre         = 1'b0;
    new_post        = 1'b0;
    new_code        = EV_DONE;
    new_ev_phase    = PH_IDLE;
    new_qty         = 3'd0;
    new_qid         = QID_ENERGY;
    new_req         = 4'd0;
    new_sel         = REQ_R1;
    if (accept) begin
      if (item.req_type == REQ_TICK) begin
        since_poll_next = start ? '0 : poll_inc;
        since_send_next = start ? '0 : send_inc;
        phase_next      = start ? PH_WAIT_R1 : phase_a;
        // timeout event first, then possibly a fresh R1
        new_pre         = timed_out;
        new_code        = EV_TIMEOUT;
        new_ev_phase    = phase;
        new_req         = start ? 4'(REQ_LEN) : 4'd0;
        new_sel         = REQ_R1;
      end else begin
        store_we      = (rx_count < CNT_W'(FRAME_DEPTH));
        rx_count_next = cnt_inc;
        if (item.rx_last) begin
          rx_count_next = '0;
          new_code      = EV_PARSE;
          new_ev_phase  = phase;
          case (phase)
            PH_WAIT_R1: begin
              if ((cnt_inc >= CNT_W'(LEN_R1)) && hdr_r1) begin
                new_qty         = 3'd5;
                new_qid         = QID_ENERGY;
                new_req         = 4'(REQ_LEN);
                new_sel         = REQ_R2;
                since_send_next = '0;
                phase_next      = PH_WAIT_R2;
              end else begin
                new_pre    = 1'b1;
                phase_next = PH_IDLE;
              end
            end
            PH_WAIT_R2: begin
              if ((cnt_inc >= CNT_W'(LEN_SHORT)) && hdr_short) begin
                new_qty         = 3'd1;
                new_qid         = QID_FLOW;
                new_req         = 4'(REQ_LEN);
                new_sel         = REQ_R3;
                since_send_next = '0;
                phase_next      = PH_WAIT_R3;
              end else begin
                new_pre    = 1'b1;
                phase_next = PH_IDLE;
              end
            end
            PH_WAIT_R3: begin
              if ((cnt_inc >= CNT_W'(LEN_SHORT)) && hdr_short) begin
                new_qty  = 3'd1;
                new_qid  = QID_POWER;
                new_post = 1'b1;
                new_code = EV_DONE;
              end else begin
                new_pre = 1'b1;
              end
              phase_next = PH_IDLE;
            end
            default: begin
              // frame in idle: drop it silently
              phase_next = PH_IDLE;
            end
          endcase
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result selection from the head of the plan.
  // ---------------------------------------------------------------------------
  always_comb begin
    case (plan_qid)
      QID_ENERGY: qty_word = {frame_store[3],  frame_store[4],  frame_store[5],  frame_store[6]};
      QID_SUPPLY: qty_word = {frame_store[11], frame_store[12], frame_store[13], frame_store[14]};
      QID_RETURN: qty_word = {frame_store[15], frame_store[16], frame_store[17], frame_store[18]};
      QID_DELTA:  qty_word = {frame_store[19], frame_store[20], frame_store[21], frame_store[22]};
      QID_VOLUME: qty_word = {frame_store[23], frame_store[24], frame_store[25], frame_store[26]};
      default:    qty_word = {frame_store[3],  frame_store[4],  frame_store[5],  frame_store[6]};
    endcase
  end

  assign req_idx = 3'(4'(REQ_LEN) - plan_req);

  always_comb begin
    result_next = '0;
    last_now    = 1'b0;
    if (plan_pre) begin
      result_next.out_kind    = KIND_EVENT;
      result_next.event_code  = plan_code;
      result_next.event_phase = plan_ev_phase;
      last_now = (plan_qty == 3'd0) && (plan_req == 4'd0) && !plan_post;
    end else if (plan_qty != 3'd0) begin
      result_next.out_kind       = KIND_QTY;
      result_next.quantity_id    = plan_qid;
      result_next.quantity_value = qty_word;
      last_now = (plan_qty == 3'd1) && (plan_req == 4'd0) && !plan_post;
    end else if (plan_req != 4'd0) begin
      result_next.out_kind = KIND_TX;
      result_next.tx_byte  = req_byte(plan_sel, req_idx);
      result_next.tx_end   = (plan_req == 4'd1);
      last_now = (plan_req == 4'd1) && !plan_post;
    end else begin
      result_next.out_kind    = KIND_EVENT;
      result_next.event_code  = plan_code;
      result_next.event_phase = plan_ev_phase;
      last_now = 1'b1;
    end
    result_next.run_last = last_now;
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      poll_limit_ms <= POLL_W'(POLL_INTERVAL_RST) * POLL_W'(MS_PER_S);
      timeout_lim   <= TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_POLL_INTERVAL: poll_limit_ms <= POLL_W'(cfg_data[7:0]) * POLL_W'(MS_PER_S);
        CFG_TIMEOUT:       timeout_lim   <= cfg_data;
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      since_poll_ms <= '0;
      since_send_ms <= '0;
      rx_count      <= '0;
    end else begin
      phase         <= phase_next;
      since_poll_ms <= since_poll_next;
      since_send_ms <= since_send_next;
      rx_count      <= rx_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      frame_store[rx_count[IDX_W-1:0]] <= item.rx_byte;
    end
  end

  // plan: replace on a transfer, else consume the head on each load
  always_ff @(posedge clk) begin
    if (rst) begin
      plan_pre  <= 1'b0;
      plan_post <= 1'b0;
      plan_qty  <= 3'd0;
      plan_req  <= 4'd0;
    end else if (accept) begin
      plan_pre  <= new_pre;
      plan_post <= new_post;
      plan_qty  <= new_qty;
      plan_req  <= new_req;
    end else if (load) begin
      if (plan_pre) begin
        plan_pre <= 1'b0;
      end else if (plan_qty != 3'd0) begin
        plan_qty <= plan_qty - 3'd1;
      end else if (plan_req != 4'd0) begin
        plan_req <= plan_req - 4'd1;
      end else begin
        plan_post <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      plan_code     <= new_code;
      plan_ev_phase <= new_ev_phase;
      plan_qid      <= new_qid;
      plan_sel      <= new_sel;
    end else if (load && !plan_pre && (plan_qty != 3'd0)) begin
      plan_qid <= plan_qid + 3'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `MMPS_ASSERT_ALWAYS(a_rx_count_bound, clk, rst, rx_count <= CNT_W'(FRAME_DEPTH))
  `MMPS_ASSERT_IMPLY(a_tx_end_last, clk, rst, result_valid && (result.out_kind == KIND_TX) && result.tx_end, result.run_last)
  `MMPS_ASSERT_NEXT(a_run_no_gap, clk, rst, result_valid && !result_stall && !result.run_last, result_valid)

endmodule
